### design/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// types, constants and the front-of-queue decode shared by the utf8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd65536;

    localparam logic [20:0] REPL_CP    = 21'h00FFFD;
    localparam logic [7:0]  ASCII_LIM  = 8'h80;
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_VAL  = 8'hF0;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_VAL   = 8'h80;

    typedef logic [3:0][7:0] byte_q_t;

    typedef struct packed {
        logic        emit;
        logic        rep;
        logic [20:0] cp;
        logic [2:0]  used;
    } dec_t;

    function automatic dec_t decode_front(input byte_q_t q, input logic [2:0] n,
                                          input logic fin);
        dec_t       d;
        logic [7:0] b0;
        logic [1:0] extra;
        logic       lead_ok;
        logic       cont_bad;
        logic [2:0] avail;
        d        = '0;
        d.used   = 3'd1;
        b0       = q[0];
        extra    = 2'd0;
        lead_ok  = 1'b1;
        cont_bad = 1'b0;
        avail    = (n == 3'd0) ? 3'd0 : n - 3'd1;
        priority if (b0 < ASCII_LIM)
            extra = 2'd0;
        else if ((b0 & LEAD2_MASK) == LEAD2_VAL)
            extra = 2'd1;
        else if ((b0 & LEAD3_MASK) == LEAD3_VAL)
            extra = 2'd2;
        else if ((b0 & LEAD4_MASK) == LEAD4_VAL)
            extra = 2'd3;
        else
            lead_ok = 1'b0;
        for (int k = 1; k < 4; k++)
        begin
            if (3'(k) <= {1'b0, extra} && 3'(k) <= avail
                && (q[k] & CONT_MASK) != CONT_VAL)
                cont_bad = 1'b1;
        end
        if (n == 3'd0)
        begin
            d.emit = 1'b0;
        end
        else if (!lead_ok || cont_bad)
        begin
            d.emit = 1'b1;
            d.rep  = 1'b1;
            d.cp   = REPL_CP;
        end
        else if (avail >= {1'b0, extra})
        begin
            d.emit = 1'b1;
            d.used = {1'b0, extra} + 3'd1;
            unique case (extra)
                2'd0: d.cp = {13'd0, b0};
                2'd1: d.cp = {10'd0, b0[4:0], q[1][5:0]};
                2'd2: d.cp = {5'd0, b0[3:0], q[1][5:0], q[2][5:0]};
                2'd3: d.cp = {b0[2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
                default: d.cp = REPL_CP;
            endcase
        end
        else if (fin)
        begin
            d.emit = 1'b1;
            d.rep  = 1'b1;
            d.cp   = REPL_CP;
        end
        else
        begin
            d.emit = 1'b0;
        end
        return d;
    endfunction

endpackage

### design/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// streaming utf8 decoder: bytes in, code points with start offsets out
//
// input channel: in_valid / in_stall with byte_value and final_byte, one
// text byte per transfer, final_byte on the last byte of a text.
// output channel: out_valid / out_stall with code_point, start_offset,
// replaced, run_last and text_last, one code point per transfer.
// a byte goes through an input register and the decode logic into the
// output register; throughput one byte per cycle while in_stall is low.
// a byte that releases several code points (replay after a malformed
// sequence, or a flush on the final byte) holds the decode stage until
// all are out, one result per cycle from the single output register
// while out_stall is low; in_stall is raised while they are released.
// when out_stall is high the output register holds and at most one more
// byte is taken into the input register before in_stall rises.
// reset clears the held bytes, the byte offset and both valid flags; the
// block is ready to take a byte as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
    parameter longint unsigned MAX_TEXT_BYTES = utf8d_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [15:0] start_offset,
    output logic        replaced,
    output logic        run_last,
    output logic        text_last
);

    localparam logic [15:0] CNT_CAP = (MAX_TEXT_BYTES - 64'd1 < 64'd65535)
                                      ? 16'(MAX_TEXT_BYTES - 64'd1) : 16'hFFFF;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_fin_reg;

    logic                  busy_reg, busy_next;
    logic                  busy_fin_reg, busy_fin_next;
    logic [2:0][7:0]       hq_reg, hq_next;
    logic [2:0][15:0]      hoff_reg, hoff_next;
    logic [1:0]            hcnt_reg, hcnt_next;
    logic [15:0]           cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [20:0]           cp_reg, cp_next;
    logic [15:0]           off_reg, off_next;
    logic                  rep_reg, rep_next;
    logic                  run_last_reg, run_last_next;
    logic                  text_last_reg, text_last_next;

    utf8d_pkg::byte_q_t    cq;
    logic [3:0][15:0]      coff;
    logic [2:0]            cn;
    logic                  cfin;
    logic                  have;
    logic                  fire;
    utf8d_pkg::dec_t       d;
    utf8d_pkg::dec_t       d2;
    utf8d_pkg::byte_q_t    rq;
    logic [2:0][15:0]      roff;
    logic [2:0]            rn;
    logic                  cont;

    // queue in front of the decoder
    always_comb
    begin
        logic [1:0] back;
        cq   = '0;
        coff = '0;
        cn   = 3'd0;
        cfin = 1'b0;
        have = 1'b0;
        back = 2'd0;
        if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cq[i]   = hq_reg[i];
                coff[i] = hoff_reg[i];
            end
            cn   = {1'b0, hcnt_reg};
            cfin = busy_fin_reg;
            have = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < hcnt_reg)
                begin
                    back    = hcnt_reg - 2'(i);
                    cq[i]   = hq_reg[i];
                    coff[i] = (cnt_reg >= {14'd0, back}) ? cnt_reg - {14'd0, back} : 16'd0;
                end
            end
            cq[hcnt_reg]   = in_byte_reg;
            coff[hcnt_reg] = cnt_reg;
            cn   = {1'b0, hcnt_reg} + 3'd1;
            cfin = in_fin_reg;
            have = in_valid_reg;
        end
    end

    assign fire = have && (!out_valid_reg || !out_stall);
    assign d    = utf8d_pkg::decode_front(cq, cn, cfin);

    // queue after the front code point is taken
    always_comb
    begin
        logic [2:0] j;
        rq   = '0;
        roff = '0;
        j    = 3'd0;
        for (int i = 0; i < 3; i++)
        begin
            j = 3'(i) + d.used;
            if (j < 3'd4)
            begin
                rq[i]   = cq[j[1:0]];
                roff[i] = coff[j[1:0]];
            end
        end
        rn = (cn >= d.used) ? cn - d.used : 3'd0;
    end

    assign d2   = utf8d_pkg::decode_front(rq, rn, cfin);
    assign cont = d.emit && d2.emit;

    assign in_stall = in_valid_reg && !(fire && !busy_reg);

    always_comb
    begin
        in_valid_next  = in_stall ? in_valid_reg : in_valid;
        busy_next      = busy_reg;
        busy_fin_next  = busy_fin_reg;
        hq_next        = hq_reg;
        hoff_next      = hoff_reg;
        hcnt_next      = hcnt_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cp_next        = cp_reg;
        off_next       = off_reg;
        rep_next       = rep_reg;
        run_last_next  = run_last_reg;
        text_last_next = text_last_reg;
        if (fire)
        begin
            if (!busy_reg && cnt_reg < CNT_CAP)
                cnt_next = cnt_reg + 16'd1;
            if (d.emit)
            begin
                out_valid_next = 1'b1;
                cp_next        = d.cp;
                off_next       = coff[0];
                rep_next       = d.rep;
                run_last_next  = !cont;
                text_last_next = !cont && cfin;
                hq_next        = rq[2:0];
                hoff_next      = roff;
                hcnt_next      = rn[1:0];
                busy_next      = cont;
                busy_fin_next  = cfin;
                if (!cont && cfin)
                begin
                    hcnt_next = 2'd0;
                    cnt_next  = 16'd0;
                end
            end
            else
            begin
                // unfinished sequence stays held
                hq_next   = cq[2:0];
                hcnt_next = cn[1:0];
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            busy_fin_reg  <= 1'b0;
            hcnt_reg      <= 2'd0;
            cnt_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            busy_fin_reg  <= busy_fin_next;
            hcnt_reg      <= hcnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= byte_value;
            in_fin_reg  <= final_byte;
        end
        hq_reg        <= hq_next;
        hoff_reg      <= hoff_next;
        cp_reg        <= cp_next;
        off_reg       <= off_next;
        rep_reg       <= rep_next;
        run_last_reg  <= run_last_next;
        text_last_reg <= text_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign code_point   = cp_reg;
    assign start_offset = off_reg;
    assign replaced     = rep_reg;
    assign run_last     = run_last_reg;
    assign text_last    = text_last_reg;

endmodule
